/* rtl/core/alfg_pkg.sv */
// alfg_pkg: constants, codes and shared types of the additive lagged-Fibonacci ranged draw
// no dependencies; imported by alfg_range and additive_rng_ranged_draw
`timescale 1ns / 1ps

package alfg_pkg;

  localparam int RING_SIZE    = 55;
  localparam int LAG          = 24;
  localparam int WORD_WIDTH   = 32;
  localparam int MAX_ATTEMPTS = 4096;
  localparam int RESET_LIMIT  = 256;

  localparam int LIMIT_W    = 31;
  localparam int SEED_IDX_W = 6;
  localparam int SEED_W     = 32;

  localparam int POS_W   = $clog2(RING_SIZE);
  localparam int LAG_MOD = LAG % RING_SIZE;
  localparam int SHIFT_W = $clog2(WORD_WIDTH + 1);
  localparam int BITS_W  = $clog2(LIMIT_W + 1);
  localparam int ATT_W   = $clog2(MAX_ATTEMPTS);
  localparam int CAND_W  = (WORD_WIDTH > LIMIT_W) ? WORD_WIDTH : LIMIT_W;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_DRAW = 1'b1
  } func_t;

  typedef struct packed {
    logic               busy;
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] mask;
    logic [SHIFT_W-1:0] shift;
  } range_t;

endpackage

/* rtl/core/alfg_ram.sv */
// alfg_ram: generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module alfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/alfg_range.sv */
// alfg_range: limit register and iterative mask and shift search for the ranged draw
// depends on alfg_pkg
`timescale 1ns / 1ps

module alfg_range (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [alfg_pkg::LIMIT_W-1:0]  cfg_range_limit,
  output alfg_pkg::range_t              rng
);

  import alfg_pkg::*;

  logic               busy_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] mask_r;
  logic [BITS_W-1:0]  bits_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [SHIFT_W-1:0] shift_nxt;
  logic               cfg_fire;

  assign cfg_ready = !busy_r;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // no shift when the mask is wider than a ring word
  assign shift_nxt = (int'(bits_r) > WORD_WIDTH) ? '0
                                                   : SHIFT_W'(WORD_WIDTH - int'(bits_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      limit_r <= LIMIT_W'(RESET_LIMIT);
      mask_r  <= LIMIT_W'(1);
      bits_r  <= BITS_W'(1);
      shift_r <= '0;
    end else if (cfg_fire) begin
      busy_r  <= 1'b1;
      limit_r <= (cfg_range_limit == '0) ? LIMIT_W'(1) : cfg_range_limit;
      mask_r  <= LIMIT_W'(1);
      bits_r  <= BITS_W'(1);
    end else if (busy_r) begin
      if (limit_r > mask_r) begin
        mask_r <= {mask_r[LIMIT_W-2:0], 1'b1};
        bits_r <= bits_r + 1'b1;
      end else begin
        busy_r  <= 1'b0;
        shift_r <= shift_nxt;
      end
    end
  end

  assign rng.busy  = busy_r;
  assign rng.limit = limit_r;
  assign rng.mask  = mask_r;
  assign rng.shift = shift_r;

  a_mask_ones: assert property (@(posedge clk) disable iff (!rst_n)
    ((mask_r + 1'b1) & mask_r) == '0)
    else $error("range mask is not a run of low ones");

  a_limit_covered: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (limit_r <= mask_r))
    else $error("settled mask below the limit");

  a_write_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> busy_r)
    else $error("limit write did not start the mask search");

endmodule

/* rtl/core/additive_rng_ranged_draw.sv */
// additive_rng_ranged_draw: top level, ring sequencer with shared adder and ring ram
// depends on alfg_pkg, alfg_ram and alfg_range
`timescale 1ns / 1ps

// A load request writes one seed word into the 55-entry ring when its index is below 55 and
// sets the ring position to zero, with no result. Each attempt of a draw request reads the
// current word and the word 24 places behind it through the single read port of the ring
// ram, then adds them, writes the sum back and tests the candidate in the S_ADD state; on
// average fewer than two attempts are needed, and after 4096 rejected attempts the draw ends
// with no result. The result register lets a new request in while a result still waits.
// Writing range_limit starts a mask search of one bit per cycle, during which neither port
// is ready; the same search runs after reset, for the reset limit of 256. All ring entries
// must be loaded, at least one of them odd, before any draw.
module additive_rng_ranged_draw (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [alfg_pkg::SEED_IDX_W-1:0] in_seed_index,
  input  logic [alfg_pkg::SEED_W-1:0]     in_seed_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [alfg_pkg::LIMIT_W-1:0]    out_drawn_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [alfg_pkg::LIMIT_W-1:0]    cfg_range_limit
);

  import alfg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_B,
    S_ADD,
    S_WAIT
  } state_t;

  state_t              state_r;
  range_t              rng;
  logic [POS_W-1:0]    pos_r;
  logic [ATT_W-1:0]    attempt_r;
  logic [WORD_WIDTH-1:0] a_r;
  logic [LIMIT_W-1:0]  cand_r;
  logic                out_valid_r;
  logic [LIMIT_W-1:0]  out_drawn_value_r;

  logic                  in_fire;
  logic                  load_fire;
  logic                  draw_fire;
  logic                  idx_ok;
  logic [POS_W:0]        pos_ext;
  logic [POS_W:0]        other_sum;
  logic [POS_W-1:0]      other_pos;
  logic [POS_W-1:0]      pos_inc;
  logic [WORD_WIDTH-1:0] sum;
  logic [WORD_WIDTH-1:0] shifted;
  logic [CAND_W-1:0]     cand_ext;
  logic [LIMIT_W-1:0]    cand;
  logic                  cand_ok;
  logic                  last_attempt;
  logic                  slot_free;
  logic                  push_out;

  logic                  ram_we;
  logic [POS_W-1:0]      ram_waddr;
  logic [WORD_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [POS_W-1:0]      ram_raddr;
  logic [WORD_WIDTH-1:0] ram_rdata;

  alfg_range u_range (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_range_limit (cfg_range_limit),
    .rng             (rng)
  );

  alfg_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (RING_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE) && !rng.busy;
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (in_func == FUNC_LOAD);
  assign draw_fire = in_fire && (in_func == FUNC_DRAW);
  assign idx_ok    = int'(in_seed_index) < RING_SIZE;

  // lagged partner and next position
  assign pos_ext   = {1'b0, pos_r};
  assign other_sum = (int'(pos_r) >= LAG_MOD) ? pos_ext - (POS_W+1)'(LAG_MOD)
                                              : pos_ext + (POS_W+1)'(RING_SIZE - LAG_MOD);
  assign other_pos = other_sum[POS_W-1:0];
  assign pos_inc   = (int'(pos_r) == RING_SIZE - 1) ? '0 : pos_r + 1'b1;

  // shared adder and candidate test
  assign sum          = a_r + ram_rdata;
  assign shifted      = sum >> rng.shift;
  assign cand_ext     = CAND_W'(shifted);
  assign cand         = cand_ext[LIMIT_W-1:0] & rng.mask;
  assign cand_ok      = cand < rng.limit;
  assign last_attempt = attempt_r == ATT_W'(MAX_ATTEMPTS - 1);
  assign slot_free    = !out_valid_r || out_ready;
  assign push_out     = ((state_r == S_ADD) && cand_ok && slot_free)
                     || ((state_r == S_WAIT) && slot_free);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = sum;
    ram_re    = 1'b0;
    ram_raddr = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (load_fire && idx_ok) begin
          ram_we    = 1'b1;
          ram_waddr = POS_W'(in_seed_index);
          ram_wdata = WORD_WIDTH'(in_seed_word);
        end
        ram_re = draw_fire;
      end
      S_RD_B: begin
        ram_re    = 1'b1;
        ram_raddr = other_pos;
      end
      S_ADD: begin
        ram_we    = 1'b1;
        ram_re    = !cand_ok && !last_attempt;
        ram_raddr = pos_inc;
      end
      S_WAIT: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      attempt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !push_out) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (load_fire) begin
            pos_r <= '0;
          end else if (draw_fire) begin
            attempt_r <= '0;
            state_r   <= S_RD_B;
          end
        end
        S_RD_B: begin
          a_r     <= ram_rdata;
          state_r <= S_ADD;
        end
        S_ADD: begin
          pos_r <= pos_inc;
          if (cand_ok) begin
            if (slot_free) begin
              out_valid_r       <= 1'b1;
              out_drawn_value_r <= cand;
              state_r           <= S_IDLE;
            end else begin
              cand_r  <= cand;
              state_r <= S_WAIT;
            end
          end else if (last_attempt) begin
            state_r <= S_IDLE;
          end else begin
            attempt_r <= attempt_r + 1'b1;
            state_r   <= S_RD_B;
          end
        end
        S_WAIT: begin
          if (slot_free) begin
            out_valid_r       <= 1'b1;
            out_drawn_value_r <= cand_r;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drawn_value = out_drawn_value_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pos_r) < RING_SIZE)
    else $error("ring position beyond the ring");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_ADD || $past(state_r) == S_WAIT))
    else $error("result raised outside a draw");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (push_out && state_r == S_ADD) |-> (cand < rng.limit))
    else $error("result at or above the limit");

  a_no_write_on_lag_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_B) |-> !ram_we)
    else $error("ring written while fetching the lagged word");

endmodule
